/* hw/rtl/bftm_pkg.sv */
// ----------------------------------------------------------------------------
// bftm_pkg
// Shared types and constants of the token run merger and bracket matcher.
// ----------------------------------------------------------------------------
package bftm_pkg;

  // Sizing of the label stack and of the result fields.
  localparam int STACK_DEPTH = 64;
  localparam int DELTA_W     = 16;
  localparam int LABEL_W     = 16;

  // Derived widths. The stack level must be able to hold STACK_DEPTH itself.
  localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int LVL_W  = $clog2(STACK_DEPTH + 1);

  // Request queue between the front and back parts.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Input token codes; every other code is a bad token.
  typedef enum logic [3:0] {
    TOK_INC   = 4'd0,
    TOK_DEC   = 4'd1,
    TOK_RIGHT = 4'd2,
    TOK_LEFT  = 4'd3,
    TOK_OPEN  = 4'd4,
    TOK_CLOSE = 4'd5,
    TOK_MEM   = 4'd6,
    TOK_SYS   = 4'd7
  } tok_e;

  // Result opcodes.
  typedef enum logic [2:0] {
    OP_CHG_VAL    = 3'd0,
    OP_CHG_PTR    = 3'd1,
    OP_LOOP_BEGIN = 3'd2,
    OP_LOOP_END   = 3'd3,
    OP_MEM_ADDR   = 3'd4,
    OP_SYSCALL    = 3'd5
  } op_e;

  // Stream status codes reported on the final result.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNMATCHED = 3'd1,
    ST_UNCLOSED  = 3'd2,
    ST_STACK_OVF = 3'd3,
    ST_BAD_TOKEN = 3'd4,
    ST_LABEL_OVF = 3'd5
  } status_e;

  // Kind of the pending run.
  typedef enum logic [1:0] {
    RUN_NONE = 2'd0,
    RUN_VAL  = 2'd1,
    RUN_PTR  = 2'd2
  } run_kind_e;

  // One result request as it travels through the queue, together with the
  // label stack access that the back part performs for it.
  typedef struct packed {
    op_e                       op;
    logic signed [DELTA_W-1:0] delta;
    logic [LABEL_W-1:0]        label;
    status_e                   status;
    logic                      last;
    logic                      mem_wr;
    logic                      mem_rd;
    logic [ADDR_W-1:0]         addr;
  } entry_t;

  // Up to two requests written into the queue in one cycle.
  typedef struct packed {
    logic [1:0] cnt;
    entry_t     e0;
    entry_t     e1;
  } qwr_t;

endpackage

/* hw/rtl/bftm_front.sv */
// ----------------------------------------------------------------------------
// bftm_front
// Accepts tokens, merges runs, tracks stack level, labels and the sticky
// error, and writes zero to two result requests into the queue per token.
// ----------------------------------------------------------------------------
module bftm_front import bftm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       q_full_i,
  input  logic [3:0] token_i,
  input  logic       last_token_i,
  output qwr_t       qwr_o
);

  localparam logic signed [DELTA_W-1:0] DELTA_MAX = {1'b0, {(DELTA_W-1){1'b1}}};
  localparam logic signed [DELTA_W-1:0] DELTA_MIN = {1'b1, {(DELTA_W-1){1'b0}}};

  run_kind_e                 run_kind_q, run_kind_d;
  logic signed [DELTA_W-1:0] run_delta_q, run_delta_d;
  logic [LVL_W-1:0]          level_q, level_d;
  logic [LABEL_W:0]          next_label_q, next_label_d;
  status_e                   err_q, err_d;

  logic                      accept;
  logic                      is_run, run_up, is_op, is_bad;
  run_kind_e                 run_k;
  op_e                       tok_op;
  logic                      have_run, flush0, same_run;
  logic signed [DELTA_W-1:0] base_delta, new_delta;
  logic [LVL_W-1:0]          level_dec;
  logic [LABEL_W-1:0]        open_label;
  logic                      label_over, stack_full;
  status_e                   err_step;
  logic [LVL_W-1:0]          level_step;
  logic [LABEL_W:0]          label_step;
  entry_t                    slot0, slot1;
  logic                      v0, v1;

  assign accept = in_valid_i && !q_full_i;

  // Token classification.
  always_comb begin
    is_run = 1'b0;
    run_up = 1'b0;
    is_op  = 1'b0;
    is_bad = 1'b0;
    run_k  = RUN_NONE;
    tok_op = OP_CHG_VAL;
    unique case (tok_e'(token_i))
      TOK_INC: begin
        is_run = 1'b1; run_k = RUN_VAL; run_up = 1'b1;
      end
      TOK_DEC: begin
        is_run = 1'b1; run_k = RUN_VAL;
      end
      TOK_RIGHT: begin
        is_run = 1'b1; run_k = RUN_PTR; run_up = 1'b1;
      end
      TOK_LEFT: begin
        is_run = 1'b1; run_k = RUN_PTR;
      end
      TOK_OPEN: begin
        is_op = 1'b1; tok_op = OP_LOOP_BEGIN;
      end
      TOK_CLOSE: begin
        is_op = 1'b1; tok_op = OP_LOOP_END;
      end
      TOK_MEM: begin
        is_op = 1'b1; tok_op = OP_MEM_ADDR;
      end
      TOK_SYS: begin
        is_op = 1'b1; tok_op = OP_SYSCALL;
      end
      default: begin
        is_bad = 1'b1;
      end
    endcase
  end

  // Run merging with saturation.
  assign have_run   = (run_kind_q != RUN_NONE);
  assign same_run   = is_run && (run_kind_q == run_k);
  assign flush0     = have_run && (is_op || (is_run && !same_run) || (is_bad && last_token_i));
  assign base_delta = same_run ? run_delta_q : '0;

  always_comb begin
    new_delta = base_delta;
    if (run_up) begin
      if (base_delta != DELTA_MAX) new_delta = base_delta + DELTA_W'(1);
    end else begin
      if (base_delta != DELTA_MIN) new_delta = base_delta - DELTA_W'(1);
    end
  end

  // Label allocation and stack bookkeeping.
  assign label_over = next_label_q[LABEL_W];
  assign open_label = label_over ? {LABEL_W{1'b1}} : next_label_q[LABEL_W-1:0];
  assign stack_full = (level_q == LVL_W'(STACK_DEPTH));
  assign level_dec  = level_q - LVL_W'(1);

  // Per-token result requests, stack effects and sticky error.
  always_comb begin
    slot0      = '0;
    slot1      = '0;
    v0         = flush0;
    v1         = 1'b0;
    err_step   = err_q;
    level_step = level_q;
    label_step = next_label_q;

    slot0.op    = (run_kind_q == RUN_VAL) ? OP_CHG_VAL : OP_CHG_PTR;
    slot0.delta = run_delta_q;

    if (is_bad && err_step == ST_OK) err_step = ST_BAD_TOKEN;

    if (is_op) begin
      v1       = 1'b1;
      slot1.op = tok_op;
      if (tok_op == OP_LOOP_BEGIN) begin
        slot1.label = open_label;
        if (label_over) begin
          if (err_step == ST_OK) err_step = ST_LABEL_OVF;
        end else begin
          label_step = next_label_q + (LABEL_W+1)'(1);
        end
        if (stack_full) begin
          if (err_step == ST_OK) err_step = ST_STACK_OVF;
        end else begin
          slot1.mem_wr = 1'b1;
          slot1.addr   = level_q[ADDR_W-1:0];
          level_step   = level_q + LVL_W'(1);
        end
      end else if (tok_op == OP_LOOP_END) begin
        if (level_q == '0) begin
          if (err_step == ST_OK) err_step = ST_UNMATCHED;
        end else begin
          slot1.mem_rd = 1'b1;
          slot1.addr   = level_dec[ADDR_W-1:0];
          level_step   = level_dec;
        end
      end
    end else if (is_run && last_token_i) begin
      // The final token closes its own run.
      v1          = 1'b1;
      slot1.op    = (run_k == RUN_VAL) ? OP_CHG_VAL : OP_CHG_PTR;
      slot1.delta = new_delta;
    end else if (last_token_i && !flush0) begin
      // Empty final: a bare marker carries the status.
      v1 = 1'b1;
    end

    if (last_token_i) begin
      if (level_step != '0 && err_step == ST_OK) err_step = ST_UNCLOSED;
      if (v1) begin
        slot1.last   = 1'b1;
        slot1.status = err_step;
      end else begin
        slot0.last   = 1'b1;
        slot0.status = err_step;
      end
    end
  end

  // Pack requests for the queue.
  always_comb begin
    qwr_o     = '0;
    qwr_o.e0  = v0 ? slot0 : slot1;
    qwr_o.e1  = slot1;
    if (accept) qwr_o.cnt = {1'b0, v0} + {1'b0, v1};
  end

  // Next state; the end of a stream returns everything to reset values.
  always_comb begin
    run_kind_d   = run_kind_q;
    run_delta_d  = run_delta_q;
    level_d      = level_q;
    next_label_d = next_label_q;
    err_d        = err_q;
    if (accept) begin
      if (is_run) begin
        run_kind_d  = run_k;
        run_delta_d = new_delta;
      end else if (is_op) begin
        run_kind_d  = RUN_NONE;
        run_delta_d = '0;
      end
      level_d      = level_step;
      next_label_d = label_step;
      err_d        = err_step;
      if (last_token_i) begin
        run_kind_d   = RUN_NONE;
        run_delta_d  = '0;
        level_d      = '0;
        next_label_d = '0;
        err_d        = ST_OK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_kind_q   <= RUN_NONE;
      run_delta_q  <= '0;
      level_q      <= '0;
      next_label_q <= '0;
      err_q        <= ST_OK;
    end else begin
      run_kind_q   <= run_kind_d;
      run_delta_q  <= run_delta_d;
      level_q      <= level_d;
      next_label_q <= next_label_d;
      err_q        <= err_d;
    end
  end

endmodule

/* hw/rtl/bftm_queue.sv */
// ----------------------------------------------------------------------------
// bftm_queue
// Short request queue: up to two writes and one read per cycle.
// ----------------------------------------------------------------------------
module bftm_queue import bftm_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  qwr_t   qwr_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   nonempty_o,
  output entry_t head_o
);

  entry_t            slots_q [QDEPTH];
  logic [QPTR_W-1:0] head_q, head_d;
  logic [QPTR_W-1:0] tail_q, tail_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              pop;
  logic [QPTR_W-1:0] tail_next;

  // The front may write two requests, so it stalls below two free slots.
  assign full_o     = (count_q > QCNT_W'(QDEPTH - 2));
  assign nonempty_o = (count_q != '0);
  assign head_o     = slots_q[head_q];
  assign pop        = pop_i && nonempty_o;
  assign tail_next  = tail_q + QPTR_W'(1);

  // Pointer and fill count update.
  always_comb begin
    head_d  = pop ? head_q + QPTR_W'(1) : head_q;
    tail_d  = tail_q + QPTR_W'(qwr_i.cnt);
    count_d = count_q + QCNT_W'(qwr_i.cnt) - QCNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // Request storage.
  always_ff @(posedge clk_i) begin
    if (qwr_i.cnt != 2'd0) slots_q[tail_q]    <= qwr_i.e0;
    if (qwr_i.cnt == 2'd2) slots_q[tail_next] <= qwr_i.e1;
  end

endmodule

/* hw/rtl/bftm_back.sv */
// ----------------------------------------------------------------------------
// bftm_back
// Takes requests from the queue in order, performs the label stack write or
// read, and holds the result in the output register.
// ----------------------------------------------------------------------------
module bftm_back import bftm_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      nonempty_i,
  input  entry_t                    head_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [2:0]                op_o,
  output logic signed [DELTA_W-1:0] delta_o,
  output logic [LABEL_W-1:0]        label_o,
  output logic [2:0]                status_o,
  output logic                      last_result_o
);

  logic [LABEL_W-1:0] stack_mem_q [STACK_DEPTH];
  logic [LABEL_W-1:0] rd_q;
  entry_t             out_q;
  logic               out_valid_q;
  logic               take;

  // The output register refills whenever it is empty or being taken.
  assign pop_o = !out_valid_q || !out_stall_i;
  assign take  = pop_o && nonempty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload and label stack accesses, in request order.
  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= head_i;
      if (head_i.mem_wr) stack_mem_q[head_i.addr] <= head_i.label;
      if (head_i.mem_rd) rd_q <= stack_mem_q[head_i.addr];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign op_o          = out_q.op;
  assign delta_o       = out_q.delta;
  assign label_o       = out_q.mem_rd ? rd_q : out_q.label;
  assign status_o      = out_q.status;
  assign last_result_o = out_q.last;

endmodule

/* hw/rtl/bf_token_run_merge_bracket_match_top.sv */
// ----------------------------------------------------------------------------
// bf_token_run_merge_bracket_match_top
// Token run merger and loop bracket matcher.
// ----------------------------------------------------------------------------
// The block takes one token per cycle while the input is not stalled and
// emits merged change instructions, loop begin/end instructions with matched
// labels, memory and syscall instructions, with the sticky stream status on
// the final result. A token may yield two results (a run flush followed by an
// instruction) while the single output register holds one; the four-entry
// request queue between the classifier and the output stage absorbs the
// difference, and the input stalls while fewer than two queue slots are free.
// Each result is registered first in a queue slot and then in the output
// register. The label stack is a 64-entry memory with at most one access per
// result, performed in order by the output stage.
module bf_token_run_merge_bracket_match_top import bftm_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [3:0]                token_i,
  input  logic                      last_token_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [2:0]                op_o,
  output logic signed [DELTA_W-1:0] delta_o,
  output logic [LABEL_W-1:0]        label_o,
  output logic [2:0]                status_o,
  output logic                      last_result_o
);

  qwr_t   qwr;
  logic   q_full;
  logic   q_pop;
  logic   q_nonempty;
  entry_t q_head;

  assign in_stall_o = q_full;

  // Classifier and run merger.
  bftm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .q_full_i     (q_full),
    .token_i      (token_i),
    .last_token_i (last_token_i),
    .qwr_o        (qwr)
  );

  // Request queue.
  bftm_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .qwr_i      (qwr),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .nonempty_o (q_nonempty),
    .head_o     (q_head)
  );

  // Label stack and output register.
  bftm_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .nonempty_i    (q_nonempty),
    .head_i        (q_head),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .op_o          (op_o),
    .delta_o       (delta_o),
    .label_o       (label_o),
    .status_o      (status_o),
    .last_result_o (last_result_o)
  );

endmodule

/* hw/rtl/bftm_checker.sv */
// ----------------------------------------------------------------------------
// bftm_checker
// Port-level checks of the result channel of the bracket matcher.
// ----------------------------------------------------------------------------
module bftm_checker import bftm_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_i,
  input logic                      out_stall_i,
  input logic [2:0]                op_i,
  input logic signed [DELTA_W-1:0] delta_i,
  input logic [LABEL_W-1:0]        label_i,
  input logic [2:0]                status_i,
  input logic                      last_result_i
);

  // A stalled result stays and holds its opcode, delta and label.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=>
      out_valid_i && $stable(op_i) && $stable(delta_i) && $stable(label_i))
    else $error("stalled result changed");

  // Only the final result of a stream carries a status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !last_result_i |-> status_i == ST_OK)
    else $error("status on a non-final result");

  // Deltas belong to change instructions only.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && op_i != OP_CHG_VAL && op_i != OP_CHG_PTR |-> delta_i == '0)
    else $error("delta on a non-change instruction");

  // Labels belong to loop instructions only.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && op_i != OP_LOOP_BEGIN && op_i != OP_LOOP_END |-> label_i == '0)
    else $error("label on a non-loop instruction");

endmodule

bind bf_token_run_merge_bracket_match_top bftm_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .op_i          (op_o),
  .delta_i       (delta_o),
  .label_i       (label_o),
  .status_i      (status_o),
  .last_result_i (last_result_o)
);
